// ===== rtl/salsa_pkg.sv =====
// shared types, constants and round functions for the salsa20 keystream block
package salsa_pkg;

    localparam int ROUND_COUNT  = 20;
    localparam int DROUND_COUNT = (ROUND_COUNT + 1) / 2;
    localparam int RND_W        = (DROUND_COUNT > 1) ? $clog2(DROUND_COUNT) : 1;

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    // register indexes on the configuration port
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] blk_t;

    typedef struct packed {
        logic [3:0][63:0] key;
        logic [63:0]      nonce;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] ctr;
    } ctr_xfer_t;

    typedef struct packed {
        logic valid;
        blk_t words;
    } blk_xfer_t;

    function automatic word_t rotl(input word_t v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic blk_t quarter(input blk_t w, input int a, input int b,
                                     input int c, input int dd);
        blk_t r;
        r = w;
        r[b]  = r[b]  ^ rotl(r[a] + r[dd], 7);
        r[c]  = r[c]  ^ rotl(r[b] + r[a], 9);
        r[dd] = r[dd] ^ rotl(r[c] + r[b], 13);
        r[a]  = r[a]  ^ rotl(r[dd] + r[c], 18);
        return r;
    endfunction

    function automatic blk_t double_round(input blk_t w);
        blk_t r;
        r = w;
        // column round
        r = quarter(r, 0, 4, 8, 12);
        r = quarter(r, 5, 9, 13, 1);
        r = quarter(r, 10, 14, 2, 6);
        r = quarter(r, 15, 3, 7, 11);
        // row round
        r = quarter(r, 0, 1, 2, 3);
        r = quarter(r, 5, 6, 7, 4);
        r = quarter(r, 10, 11, 8, 9);
        r = quarter(r, 15, 12, 13, 14);
        return r;
    endfunction

    function automatic blk_t init_state(input cfg_t cfg, input logic [63:0] ctr);
        blk_t s;
        s[0]  = SIGMA0;
        s[1]  = cfg.key[0][31:0];
        s[2]  = cfg.key[0][63:32];
        s[3]  = cfg.key[1][31:0];
        s[4]  = cfg.key[1][63:32];
        s[5]  = SIGMA1;
        s[6]  = cfg.nonce[31:0];
        s[7]  = cfg.nonce[63:32];
        s[8]  = ctr[31:0];
        s[9]  = ctr[63:32];
        s[10] = SIGMA2;
        s[11] = cfg.key[2][31:0];
        s[12] = cfg.key[2][63:32];
        s[13] = cfg.key[3][31:0];
        s[14] = cfg.key[3][63:32];
        s[15] = SIGMA3;
        return s;
    endfunction

endpackage

// ===== rtl/salsa_front.sv =====
// input side: accepts block counters into a two-entry queue
module salsa_front import salsa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] block_counter
    output ctr_xfer_t   ctr_out,
    input  logic        ctr_ready
);

    logic [1:0][63:0] mem_reg;
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign s_tready      = (count_reg != 2'd2);
    assign push          = s_tvalid && s_tready;
    assign ctr_out.valid = (count_reg != 2'd0);
    assign ctr_out.ctr   = mem_reg[rd_ptr_reg];
    assign pop           = ctr_out.valid && ctr_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_tdata;
        end
    end

endmodule

// ===== rtl/salsa_core.sv =====
// round engine: one double round per cycle, then the feed-forward add
module salsa_core import salsa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  ctr_xfer_t ctr_in,
    output logic      ctr_ready,
    output blk_xfer_t blk_out,
    input  logic      blk_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    blk_t             w_reg, w_next;
    logic [63:0]      ctr_reg, ctr_next;
    blk_t             init_w;

    assign init_w = init_state(cfg, ctr_reg);

    always_comb begin
        blk_out.valid = (state_reg == ST_DONE);
        for (int i = 0; i < 16; i++) begin
            blk_out.words[i] = w_reg[i] + init_w[i];
        end
    end

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        w_next     = w_reg;
        ctr_next   = ctr_reg;
        ctr_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                ctr_ready = 1'b1;
            end
            ST_RUN: begin
                w_next   = double_round(w_reg);
                rnd_next = rnd_reg + RND_W'(1);
                if (rnd_reg == RND_W'(DROUND_COUNT - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (blk_ready) begin
                    ctr_ready  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // load the next counter straight away when the engine frees up
        if (ctr_ready && ctr_in.valid) begin
            w_next     = init_state(cfg, ctr_in.ctr);
            ctr_next   = ctr_in.ctr;
            rnd_next   = '0;
            state_next = ST_RUN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg   <= w_next;
        ctr_reg <= ctr_next;
    end

endmodule

// ===== rtl/salsa_drain.sv =====
// output side: holds a finished block and sends it as eight 64-bit beats
module salsa_drain import salsa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  blk_xfer_t   blk_in,
    output logic        blk_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] keystream_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    blk_t       buf_reg;
    logic       valid_reg, valid_next;
    logic [2:0] idx_reg, idx_next;
    logic       beat;

    assign m_tvalid  = valid_reg;
    assign m_tdata   = {buf_reg[{idx_reg, 1'b1}], buf_reg[{idx_reg, 1'b0}]};
    assign m_tuser   = idx_reg;
    assign m_tlast   = (idx_reg == 3'd7);
    assign beat      = m_tvalid && m_tready;
    // free when empty or when the final beat leaves this cycle
    assign blk_ready = !valid_reg || (beat && m_tlast);

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (beat) begin
            idx_next = idx_reg + 3'd1;
            if (m_tlast) begin
                valid_next = 1'b0;
            end
        end
        if (blk_ready && blk_in.valid) begin
            valid_next = 1'b1;
            idx_next   = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (blk_ready && blk_in.valid) begin
            buf_reg <= blk_in.words;
        end
    end

endmodule

// ===== rtl/salsa20_keystream_block.sv =====
// a counter passes the queue, the round engine and the output buffer in turn
// the round engine runs its 10-pass double-round loop on each 64-byte block and
// takes the next counter as it hands the block on; the 8 beats drain meanwhile
// a two-entry counter queue lets input and output stall independently
// reset (synchronous, active low) empties the queue and output, clears key and nonce
module salsa20_keystream_block import salsa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] block_counter
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] keystream_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast,   // last_word
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;
    ctr_xfer_t  ctr_x;
    logic       ctr_ready;
    blk_xfer_t  blk_x;
    logic       blk_ready;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_KEY0:  cfg_next.key[0] = pwdata;
                REG_KEY1:  cfg_next.key[1] = pwdata;
                REG_KEY2:  cfg_next.key[2] = pwdata;
                REG_KEY3:  cfg_next.key[3] = pwdata;
                REG_NONCE: cfg_next.nonce  = pwdata;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KEY0:  prdata = cfg_reg.key[0];
            REG_KEY1:  prdata = cfg_reg.key[1];
            REG_KEY2:  prdata = cfg_reg.key[2];
            REG_KEY3:  prdata = cfg_reg.key[3];
            REG_NONCE: prdata = cfg_reg.nonce;
            default:   prdata = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    salsa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .ctr_out   (ctr_x),
        .ctr_ready (ctr_ready)
    );

    salsa_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .ctr_in    (ctr_x),
        .ctr_ready (ctr_ready),
        .blk_out   (blk_x),
        .blk_ready (blk_ready)
    );

    salsa_drain u_drain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .blk_in    (blk_x),
        .blk_ready (blk_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== test/tb_salsa20_keystream_block.sv =====
// testbench for salsa20_keystream_block: directed table, random counters, keystream predictor
`timescale 1ns / 100ps

module tb_salsa20_keystream_block import salsa_pkg::*;;

    localparam int ITEMS_PER_PHASE = 120;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SCRIPT_ROWS     = 30;

    // unused register slots, writes there must be dropped
    localparam logic [2:0] REG_SPARE5 = 3'd5;
    localparam logic [2:0] REG_SPARE7 = 3'd7;

    // quarter-round word order, 16 bits per quarter-round as {d, c, b, a}, first in low bits
    localparam logic [127:0] MIX_ORDER = 128'hEDCF_98BA_4765_3210_B73F_62EA_1D95_C840;

    typedef logic [7:0][63:0] keystream_t;

    typedef struct packed {
        logic [63:0] ks;
        logic [2:0]  idx;
        logic        last;
    } beat_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_READ, ROW_BLOCK} row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [2:0]  idx;
        logic [63:0] value;
    } row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // [63:0] block_counter
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // [63:0] keystream_word
    logic [2:0]  m_tuser;         // [2:0] word_index
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [5:0]  paddr    = '0;
    logic [63:0] pwdata   = '0;
    logic [63:0] prdata;
    logic        pready;

    cfg_t        cfg_shadow = '0;
    beat_t       beats_due[$];
    beat_t       due_beat;
    logic [63:0] seq_ctr = '0;
    bit          failed = 1'b0;
    bit          hold_req = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          stall_count = 0;

    // byte-pattern key rows follow the usual little-endian test layout
    row_t script [SCRIPT_ROWS] = '{
        '{ROW_READ,  REG_KEY0,   64'h0},
        '{ROW_READ,  REG_NONCE,  64'h0},
        '{ROW_BLOCK, REG_KEY0,   64'h0},
        '{ROW_BLOCK, REG_KEY0,   64'hffff_ffff_ffff_ffff},
        '{ROW_WRITE, REG_KEY0,   64'hffff_ffff_ffff_ffff},
        '{ROW_WRITE, REG_KEY1,   64'hffff_ffff_ffff_ffff},
        '{ROW_WRITE, REG_KEY2,   64'hffff_ffff_ffff_ffff},
        '{ROW_WRITE, REG_KEY3,   64'hffff_ffff_ffff_ffff},
        '{ROW_WRITE, REG_NONCE,  64'hffff_ffff_ffff_ffff},
        '{ROW_READ,  REG_KEY3,   64'hffff_ffff_ffff_ffff},
        '{ROW_BLOCK, REG_KEY0,   64'h0},
        '{ROW_BLOCK, REG_KEY0,   64'hffff_ffff_ffff_ffff},
        '{ROW_BLOCK, REG_KEY0,   64'h0000_0000_ffff_ffff},
        '{ROW_BLOCK, REG_KEY0,   64'h0000_0001_0000_0000},
        '{ROW_WRITE, REG_SPARE5, 64'h0123_4567_89ab_cdef},
        '{ROW_WRITE, REG_SPARE7, 64'h0},
        '{ROW_READ,  REG_KEY0,   64'hffff_ffff_ffff_ffff},
        '{ROW_READ,  REG_NONCE,  64'hffff_ffff_ffff_ffff},
        '{ROW_WRITE, REG_KEY0,   64'h0706_0504_0302_0100},
        '{ROW_WRITE, REG_KEY1,   64'h0f0e_0d0c_0b0a_0908},
        '{ROW_WRITE, REG_KEY2,   64'h1716_1514_1312_1110},
        '{ROW_WRITE, REG_KEY3,   64'h1f1e_1d1c_1b1a_1918},
        '{ROW_WRITE, REG_NONCE,  64'h0},
        '{ROW_READ,  REG_KEY2,   64'h1716_1514_1312_1110},
        '{ROW_BLOCK, REG_KEY0,   64'h5555_5555_5555_5555},
        '{ROW_BLOCK, REG_KEY0,   64'haaaa_aaaa_aaaa_aaaa},
        '{ROW_BLOCK, REG_KEY0,   64'h8000_0000_0000_0000},
        '{ROW_BLOCK, REG_KEY0,   64'h1},
        '{ROW_WRITE, REG_NONCE,  64'hffff_ffff_0000_0000},
        '{ROW_BLOCK, REG_KEY0,   64'h7fff_ffff_ffff_ffff}
    };

    salsa20_keystream_block uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic word_t rol32(input word_t v, input int unsigned n);
        logic [63:0] both;
        both = {v, v} << n;
        return both[63:32];
    endfunction

    function automatic keystream_t salsa_block(input logic [63:0] ctr);
        word_t      start [16];
        word_t      x [16];
        keystream_t ks;
        int         a, b, c, d;
        start[0]  = SIGMA0;
        start[1]  = cfg_shadow.key[0][31:0];
        start[2]  = cfg_shadow.key[0][63:32];
        start[3]  = cfg_shadow.key[1][31:0];
        start[4]  = cfg_shadow.key[1][63:32];
        start[5]  = SIGMA1;
        start[6]  = cfg_shadow.nonce[31:0];
        start[7]  = cfg_shadow.nonce[63:32];
        start[8]  = ctr[31:0];
        start[9]  = ctr[63:32];
        start[10] = SIGMA2;
        start[11] = cfg_shadow.key[2][31:0];
        start[12] = cfg_shadow.key[2][63:32];
        start[13] = cfg_shadow.key[3][31:0];
        start[14] = cfg_shadow.key[3][63:32];
        start[15] = SIGMA3;
        for (int i = 0; i < 16; i++) x[i] = start[i];
        // odd round counts still run whole double rounds
        for (int r = 0; r < ROUND_COUNT; r += 2) begin
            for (int q = 0; q < 8; q++) begin
                a = int'(MIX_ORDER[16*q +: 4]);
                b = int'(MIX_ORDER[16*q + 4 +: 4]);
                c = int'(MIX_ORDER[16*q + 8 +: 4]);
                d = int'(MIX_ORDER[16*q + 12 +: 4]);
                x[b] = x[b] ^ rol32(x[a] + x[d], 7);
                x[c] = x[c] ^ rol32(x[b] + x[a], 9);
                x[d] = x[d] ^ rol32(x[c] + x[b], 13);
                x[a] = x[a] ^ rol32(x[d] + x[c], 18);
            end
        end
        for (int k = 0; k < 8; k++)
            ks[k] = {x[2*k+1] + start[2*k+1], x[2*k] + start[2*k]};
        return ks;
    endfunction

    function automatic logic [63:0] pick_counter();
        int unsigned sel;
        logic [63:0] ctr;
        sel = $urandom_range(99);
        if (sel < 50) begin
            // running stream position, reseeded now and then
            if ($urandom_range(15) == 0)
                seq_ctr = {$urandom, $urandom};
            else
                seq_ctr = seq_ctr + 64'd1;
            ctr = seq_ctr;
        end else if (sel < 80) begin
            ctr = {$urandom, $urandom};
        end else begin
            case ($urandom_range(3))
                0: ctr = {$urandom, 32'hffff_ffff};
                1: ctr = {32'hffff_ffff, $urandom};
                2: ctr = 64'hffff_ffff_ffff_ffff - $urandom_range(3);
                default: ctr = {32'h0, 32'hffff_ffff - $urandom_range(3)};
            endcase
        end
        return ctr;
    endfunction

    task automatic push_counter(input logic [63:0] ctr);
        keystream_t ks;
        int         gap;
        s_tvalid <= 1'b1;
        s_tdata  <= ctr;
        do @(posedge aclk); while (!s_tready);
        ks = salsa_block(ctr);
        for (int k = 0; k < 8; k++)
            beats_due.push_back('{ks: ks[k], idx: k[2:0], last: (k == 7)});
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (beats_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_KEY0:  cfg_shadow.key[0] = value;
            REG_KEY1:  cfg_shadow.key[1] = value;
            REG_KEY2:  cfg_shadow.key[2] = value;
            REG_KEY3:  cfg_shadow.key[3] = value;
            REG_NONCE: cfg_shadow.nonce  = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [2:0] idx, input logic [63:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $error("prdata: expected %h, actual %h", want, prdata);
            failed = 1'b1;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (beats_due.size() == 0) begin
                $error("unexpected keystream beat %h", m_tdata);
                failed = 1'b1;
            end else begin
                due_beat = beats_due.pop_front();
                if (m_tdata !== due_beat.ks) begin
                    $error("keystream_word: expected %h, actual %h", due_beat.ks, m_tdata);
                    failed = 1'b1;
                end
                if (m_tuser !== due_beat.idx) begin
                    $error("word_index: expected %0d, actual %0d", due_beat.idx, m_tuser);
                    failed = 1'b1;
                end
                if (m_tlast !== due_beat.last) begin
                    $error("last_word: expected %b, actual %b", due_beat.last, m_tlast);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        while (stall_count < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                stall_count = 0;
            else
                stall_count++;
        end
        $display("salsa20_keystream_block: mismatch");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < SCRIPT_ROWS; i++) begin
            case (script[i].kind)
                ROW_BLOCK: push_counter(script[i].value);
                ROW_WRITE: begin
                    wait_idle();
                    apb_write(script[i].idx, script[i].value);
                end
                default: begin
                    wait_idle();
                    apb_read(script[i].idx, script[i].value);
                end
            endcase
        end

        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (int r = 0; r < 4; r++)
                apb_write(r[2:0], (phase == 2) ? 64'h0 : {$urandom, $urandom});
            apb_write(REG_NONCE, (phase == 1) ? 64'hffff_ffff_ffff_ffff : {$urandom, $urandom});
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // output held off while input keeps coming, then a full drain
                if (phase == 0 && n == 40) hold_req = 1'b1;
                if (phase == 0 && n == 80) wait_idle();
                push_counter(pick_counter());
            end
        end

        wait_idle();
        repeat (16) @(posedge aclk);
        if (!failed)
            $display("salsa20_keystream_block: match");
        else
            $display("salsa20_keystream_block: mismatch");
        $finish;
    end

endmodule
